>>> sv/power_monitor_register_slave_core_defines.svh
// ----------------------------------------------------------------------------
// Power monitor register slave assertion macros
// Shared concurrent assertion forms for the register slave core.
// ----------------------------------------------------------------------------
`ifndef POWER_MONITOR_REGISTER_SLAVE_CORE_DEFINES_SVH
`define POWER_MONITOR_REGISTER_SLAVE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PMRS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmrs same-cycle check failed");

// Next-cycle implication, disabled during reset
`define PMRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmrs next-cycle check failed");

`endif

>>> sv/pmrs_pkg.sv
// ----------------------------------------------------------------------------
// Power monitor register slave package
// Register addresses, identity words, code limits and sequencer states.
// ----------------------------------------------------------------------------
package pmrs_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_SET_PTR = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_READ    = 2'd2,
    KIND_MEAS    = 2'd3
  } kind_t;

  // Register map
  localparam logic [7:0] ADDR_CONFIG     = 8'h00;
  localparam logic [7:0] ADDR_ADC_CONFIG = 8'h01;
  localparam logic [7:0] ADDR_SHUNT_CAL  = 8'h02;
  localparam logic [7:0] ADDR_VBUS       = 8'h05;
  localparam logic [7:0] ADDR_CURRENT    = 8'h07;
  localparam logic [7:0] ADDR_MANUF_ID   = 8'h3E;
  localparam logic [7:0] ADDR_DEVICE_ID  = 8'h3F;

  localparam logic [15:0] MANUF_ID_VALUE  = 16'h5449;
  localparam logic [15:0] DEVICE_ID_VALUE = 16'h2280;

  // Byte counts
  localparam logic [1:0] COUNT_NONE  = 2'd0;
  localparam logic [1:0] COUNT_SHORT = 2'd2;
  localparam logic [1:0] COUNT_LONG  = 2'd3;

  // Code limits
  localparam logic [19:0] CODE_MAX     = 20'h7FFFF;
  localparam logic [19:0] CODE_MIN_MAG = 20'h80000;

  // Voltage: (r*5 + 32) >> 6
  localparam logic [31:0] VOLT_MULT  = 32'd5;
  localparam logic [33:0] VOLT_ROUND = 34'd32;

  // Current: (mag + 12) / 25 via reciprocal floor(2^36/25) and one correction
  localparam logic [31:0] AMP_ROUND  = 32'd12;
  localparam logic [31:0] AMP_RECIP  = 32'd2748779069;
  localparam logic [31:0] AMP_DIV    = 32'd25;
  localparam logic [31:0] AMP_REM_MAX = 32'd50;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MULV = 5'b00010,
    S_MULI = 5'b00100,
    S_FIX  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

>>> sv/power_monitor_register_slave_core.sv
// ----------------------------------------------------------------------------
// Power monitor register slave core
// Register map of a current/voltage monitor with a shared multiplier for
// converting Q15.16 measurements into 19-bit voltage and 20-bit current codes.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  -----------------------------------------
//   in       in_valid / in_ready  kind, reg_address, write_value,
//                                 bus_voltage, current_amps
//   out      out_valid/out_ready  read_data, byte_count
//
// Pointer set, register write and read words finish in the accept cycle:
// one word per cycle while the output register drains.
// A measurement word steps through accept, voltage multiply, current
// reciprocal multiply, quotient correction and result load, which waits
// for a free output. The one 32x32 multiplier is used twice in sequence.
// Reset clears the pointer, the three writable registers and both codes.
// in_ready drops while a measurement is in the sequencer or while a result
// waits that is not being taken.

`include "power_monitor_register_slave_core_defines.svh"

module power_monitor_register_slave_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  reg_address,
  input  logic [15:0] write_value,
  input  logic signed [31:0] bus_voltage,
  input  logic signed [31:0] current_amps,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] read_data,
  output logic [1:0]  byte_count
);

  pmrs_pkg::state_t state;
  pmrs_pkg::state_t state_next;

  logic [7:0]  register_pointer;
  logic [15:0] config_word;
  logic [15:0] adc_config_word;
  logic [15:0] shunt_cal_word;
  logic [18:0] voltage_code;
  logic [19:0] current_code;

  // measurement operands
  logic [31:0] v_op;
  logic [31:0] i_x;
  logic        i_neg;
  logic [31:0] i_mag;

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_y;
  logic [63:0] prod;

  logic [33:0] v_sum;
  logic [27:0] v_q;
  logic [18:0] v_code_next;

  logic [27:0] q_est;
  logic [31:0] q25;
  logic [31:0] rem;
  logic [27:0] q_fix;
  logic [27:0] q_neg;
  logic [19:0] i_code_next;

  logic        in_fire;
  logic        out_free;
  logic        meas_fire;
  logic        meas_done;
  logic        empty_out;
  logic        word_fire;
  logic [23:0] rd_word;
  logic [1:0]  rd_count;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == pmrs_pkg::S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign meas_fire = in_fire && (pmrs_pkg::kind_t'(kind) == pmrs_pkg::KIND_MEAS);
  assign word_fire = in_fire && (pmrs_pkg::kind_t'(kind) != pmrs_pkg::KIND_MEAS);
  assign meas_done = (state == pmrs_pkg::S_OUT) && out_free;
  assign empty_out = out_valid && (byte_count == pmrs_pkg::COUNT_NONE);

  // read mux on the current pointer
  always_comb begin
    rd_count = pmrs_pkg::COUNT_SHORT;
    case (register_pointer)
      pmrs_pkg::ADDR_CONFIG:     rd_word = {config_word, 8'h00};
      pmrs_pkg::ADDR_ADC_CONFIG: rd_word = {adc_config_word, 8'h00};
      pmrs_pkg::ADDR_SHUNT_CAL:  rd_word = {shunt_cal_word, 8'h00};
      pmrs_pkg::ADDR_MANUF_ID:   rd_word = {pmrs_pkg::MANUF_ID_VALUE, 8'h00};
      pmrs_pkg::ADDR_DEVICE_ID:  rd_word = {pmrs_pkg::DEVICE_ID_VALUE, 8'h00};
      pmrs_pkg::ADDR_VBUS: begin
        rd_word  = {1'b0, voltage_code, 4'h0};
        rd_count = pmrs_pkg::COUNT_LONG;
      end
      pmrs_pkg::ADDR_CURRENT: begin
        rd_word  = {current_code, 4'h0};
        rd_count = pmrs_pkg::COUNT_LONG;
      end
      default:                   rd_word = 24'h000000;
    endcase
  end

  // current magnitude
  assign i_mag = current_amps[31] ? (~current_amps + 32'd1) : current_amps;

  // shared multiplier operand select
  always_comb begin
    case (state)
      pmrs_pkg::S_MULV: begin
        mul_a = v_op;
        mul_b = pmrs_pkg::VOLT_MULT;
      end
      pmrs_pkg::S_MULI: begin
        mul_a = i_x;
        mul_b = pmrs_pkg::AMP_RECIP;
      end
      default: begin
        mul_a = 32'h0;
        mul_b = 32'h0;
      end
    endcase
  end

  assign mul_y = 64'(mul_a) * 64'(mul_b);

  // voltage rounding and clamp
  assign v_sum       = prod[33:0] + pmrs_pkg::VOLT_ROUND;
  assign v_q         = v_sum[33:6];
  assign v_code_next = (v_q > 28'(pmrs_pkg::CODE_MAX)) ? pmrs_pkg::CODE_MAX[18:0] : v_q[18:0];

  // current quotient correction and saturation
  assign q_est = prod[63:36];
  assign q25   = {q_est, 4'h0} + {1'b0, q_est, 3'h0} + {4'h0, q_est};
  assign rem   = i_x - q25;
  assign q_fix = q_est + 28'((rem >= pmrs_pkg::AMP_DIV) ? 1 : 0);
  assign q_neg = ~q_fix + 28'd1;

  always_comb begin
    if (i_neg) begin
      if (q_fix > 28'(pmrs_pkg::CODE_MIN_MAG)) begin
        i_code_next = pmrs_pkg::CODE_MIN_MAG;
      end else begin
        i_code_next = q_neg[19:0];
      end
    end else begin
      if (q_fix > 28'(pmrs_pkg::CODE_MAX)) begin
        i_code_next = pmrs_pkg::CODE_MAX;
      end else begin
        i_code_next = q_fix[19:0];
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      pmrs_pkg::S_IDLE: begin
        if (meas_fire) begin
          state_next = pmrs_pkg::S_MULV;
        end
      end
      pmrs_pkg::S_MULV: state_next = pmrs_pkg::S_MULI;
      pmrs_pkg::S_MULI: state_next = pmrs_pkg::S_FIX;
      pmrs_pkg::S_FIX:  state_next = pmrs_pkg::S_OUT;
      pmrs_pkg::S_OUT: begin
        if (out_free) begin
          state_next = pmrs_pkg::S_IDLE;
        end
      end
      default: state_next = pmrs_pkg::S_IDLE;
    endcase
  end

  // control state and register map
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= pmrs_pkg::S_IDLE;
      out_valid        <= 1'b0;
      register_pointer <= 8'h00;
      config_word      <= 16'h0000;
      adc_config_word  <= 16'h0000;
      shunt_cal_word   <= 16'h0000;
      voltage_code     <= 19'h0;
      current_code     <= 20'h0;
    end else begin
      state <= state_next;
      // result word loads on a map word or at the end of a measurement
      if (word_fire || meas_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        case (pmrs_pkg::kind_t'(kind))
          pmrs_pkg::KIND_SET_PTR: begin
            register_pointer <= reg_address;
          end
          pmrs_pkg::KIND_WRITE: begin
            register_pointer <= reg_address;
            case (reg_address)
              pmrs_pkg::ADDR_CONFIG:     config_word     <= write_value;
              pmrs_pkg::ADDR_ADC_CONFIG: adc_config_word <= write_value;
              pmrs_pkg::ADDR_SHUNT_CAL:  shunt_cal_word  <= write_value;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      if (state == pmrs_pkg::S_MULI) begin
        voltage_code <= v_code_next;
      end
      if (state == pmrs_pkg::S_FIX) begin
        current_code <= i_code_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      case (pmrs_pkg::kind_t'(kind))
        pmrs_pkg::KIND_READ: begin
          read_data  <= rd_word;
          byte_count <= rd_count;
        end
        pmrs_pkg::KIND_MEAS: begin
          v_op  <= bus_voltage[31] ? 32'h0 : bus_voltage;
          i_neg <= current_amps[31];
          i_x   <= i_mag + pmrs_pkg::AMP_ROUND;
        end
        default: begin
          read_data  <= 24'h000000;
          byte_count <= pmrs_pkg::COUNT_NONE;
        end
      endcase
    end
    if ((state == pmrs_pkg::S_MULV) || (state == pmrs_pkg::S_MULI)) begin
      prod <= mul_y;
    end
    if (meas_done) begin
      read_data  <= 24'h000000;
      byte_count <= pmrs_pkg::COUNT_NONE;
    end
  end

  // checks
  `PMRS_ASSERT_NEXT(a_meas_starts, clk, rst, meas_fire, state == pmrs_pkg::S_MULV)
  `PMRS_ASSERT_NOW(a_rem_bounded, clk, rst, state == pmrs_pkg::S_FIX, rem < pmrs_pkg::AMP_REM_MAX)
  `PMRS_ASSERT_NOW(a_nonread_zero, clk, rst, empty_out, read_data == 24'h000000)
  `PMRS_ASSERT_NEXT(a_meas_result, clk, rst, meas_done, empty_out && (state == pmrs_pkg::S_IDLE))

endmodule

>>> dv/tb_power_monitor_register_slave_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power monitor register slave core testbench
// Walks a table of directed words covering the register map, identity
// registers, unknown addresses and code saturation. It then sends random
// write/read-back, measurement/read, pointer/read and noise sequences.
// Every reply is checked against its typed table reply or an in-bench
// register map predictor. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_power_monitor_register_slave_core;

  localparam int RANDOM_WORDS = 750;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 12;

  // One directed stimulus row; typed rows carry their reply
  typedef struct {
    pmrs_pkg::kind_t k;
    logic [7:0]  addr;
    logic [15:0] val;
    logic [31:0] vbus;
    logic [31:0] amps;
    bit          typed;
    logic [23:0] data;
    logic [1:0]  count;
  } stim_row_t;

  typedef struct {
    logic [23:0] data;
    logic [1:0]  count;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [7:0]  reg_address;
  logic [15:0] write_value;
  logic signed [31:0] bus_voltage;
  logic signed [31:0] current_amps;
  logic        out_valid;
  logic        out_ready;
  logic [23:0] read_data;
  logic [1:0]  byte_count;

  // Predicted register map
  logic [7:0]  pred_pointer;
  logic [15:0] pred_config;
  logic [15:0] pred_adc_config;
  logic [15:0] pred_shunt_cal;
  logic [18:0] pred_vbus_code;
  logic [19:0] pred_amps_code;

  reply_t pending_replies[$];
  reply_t want_reply;
  int     errors;
  int     idle_cycles;
  bit     steady_flow;

  localparam int DIRECTED_ROWS = 28;
  stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b1, 24'h000000, pmrs_pkg::COUNT_SHORT},
    '{pmrs_pkg::KIND_SET_PTR, pmrs_pkg::ADDR_MANUF_ID, 16'h0000, 32'h0, 32'h0,
      1'b1, 24'h000000, pmrs_pkg::COUNT_NONE},
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b1, 24'h544900, pmrs_pkg::COUNT_SHORT},
    '{pmrs_pkg::KIND_SET_PTR, pmrs_pkg::ADDR_DEVICE_ID, 16'h0000, 32'h0, 32'h0,
      1'b1, 24'h000000, pmrs_pkg::COUNT_NONE},
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b1, 24'h228000, pmrs_pkg::COUNT_SHORT},
    '{pmrs_pkg::KIND_WRITE, pmrs_pkg::ADDR_CONFIG, 16'hFFFF, 32'h0, 32'h0,
      1'b1, 24'h000000, pmrs_pkg::COUNT_NONE},
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b1, 24'hFFFF00, pmrs_pkg::COUNT_SHORT},
    '{pmrs_pkg::KIND_WRITE, pmrs_pkg::ADDR_ADC_CONFIG, 16'h0000, 32'h0, 32'h0,
      1'b1, 24'h000000, pmrs_pkg::COUNT_NONE},
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b1, 24'h000000, pmrs_pkg::COUNT_SHORT},
    '{pmrs_pkg::KIND_WRITE, pmrs_pkg::ADDR_SHUNT_CAL, 16'hA5C3, 32'h0, 32'h0,
      1'b0, 24'h0, 2'd0},
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b0, 24'h0, 2'd0},
    '{pmrs_pkg::KIND_WRITE, pmrs_pkg::ADDR_CURRENT, 16'h1234, 32'h0, 32'h0,
      1'b0, 24'h0, 2'd0},
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b0, 24'h0, 2'd0},
    '{pmrs_pkg::KIND_SET_PTR, 8'h04, 16'h0000, 32'h0, 32'h0,
      1'b0, 24'h0, 2'd0},
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b1, 24'h000000, pmrs_pkg::COUNT_SHORT},
    '{pmrs_pkg::KIND_MEAS, 8'h00, 16'h0000, 32'h7FFFFFFF, 32'h7FFFFFFF,
      1'b1, 24'h000000, pmrs_pkg::COUNT_NONE},
    '{pmrs_pkg::KIND_SET_PTR, pmrs_pkg::ADDR_VBUS, 16'h0000, 32'h0, 32'h0,
      1'b0, 24'h0, 2'd0},
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b1, 24'h7FFFF0, pmrs_pkg::COUNT_LONG},
    '{pmrs_pkg::KIND_WRITE, pmrs_pkg::ADDR_CURRENT, 16'hFFFF, 32'h0, 32'h0,
      1'b0, 24'h0, 2'd0},
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b1, 24'h7FFFF0, pmrs_pkg::COUNT_LONG},
    '{pmrs_pkg::KIND_MEAS, 8'h00, 16'h0000, 32'h80000000, 32'h80000000,
      1'b1, 24'h000000, pmrs_pkg::COUNT_NONE},
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b1, 24'h800000, pmrs_pkg::COUNT_LONG},
    '{pmrs_pkg::KIND_SET_PTR, pmrs_pkg::ADDR_VBUS, 16'h0000, 32'h0, 32'h0,
      1'b0, 24'h0, 2'd0},
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b1, 24'h000000, pmrs_pkg::COUNT_LONG},
    // rounding: 32 * 5/64 = 2.5 is a tie, -13/25 rounds away from zero
    '{pmrs_pkg::KIND_MEAS, 8'h00, 16'h0000, 32'd32, 32'hFFFFFFF3,
      1'b0, 24'h0, 2'd0},
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b0, 24'h0, 2'd0},
    '{pmrs_pkg::KIND_SET_PTR, pmrs_pkg::ADDR_CURRENT, 16'h0000, 32'h0, 32'h0,
      1'b0, 24'h0, 2'd0},
    '{pmrs_pkg::KIND_READ, 8'h00, 16'h0000, 32'h0, 32'h0,
      1'b0, 24'h0, 2'd0}
  };

  power_monitor_register_slave_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .reg_address  (reg_address),
    .write_value  (write_value),
    .bus_voltage  (bus_voltage),
    .current_amps (current_amps),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .byte_count   (byte_count)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Voltage code: round(r*5/64), negative to zero, clamp at full scale
  function automatic logic [18:0] vbus_code_of(input logic signed [31:0] raw);
    longint r;
    longint q;
    r = raw;
    if (r <= 0) return '0;
    q = (r * 5 + 32) / 64;
    if (q > longint'(pmrs_pkg::CODE_MAX)) q = longint'(pmrs_pkg::CODE_MAX);
    return q[18:0];
  endfunction

  // Current code: round(r/25) half away from zero, saturate to -2^19 .. 2^19-1
  function automatic logic [19:0] amps_code_of(input logic signed [31:0] raw);
    longint r;
    longint mag;
    longint q;
    r = raw;
    mag = (r < 0) ? -r : r;
    q = (mag + 12) / 25;
    if (r < 0) begin
      if (q > longint'(pmrs_pkg::CODE_MIN_MAG)) q = longint'(pmrs_pkg::CODE_MIN_MAG);
      q = -q;
    end else if (q > longint'(pmrs_pkg::CODE_MAX)) begin
      q = longint'(pmrs_pkg::CODE_MAX);
    end
    return q[19:0];
  endfunction

  // Register map predictor: apply one word, return the reply it causes
  task automatic predict_reply(input pmrs_pkg::kind_t k, input logic [7:0] a,
                               input logic [15:0] v,
                               input logic signed [31:0] vbus,
                               input logic signed [31:0] amps,
                               output reply_t r);
    r.data  = '0;
    r.count = pmrs_pkg::COUNT_NONE;
    case (k)
      pmrs_pkg::KIND_SET_PTR: begin
        pred_pointer = a;
      end
      pmrs_pkg::KIND_WRITE: begin
        pred_pointer = a;
        if (a == pmrs_pkg::ADDR_CONFIG) pred_config = v;
        else if (a == pmrs_pkg::ADDR_ADC_CONFIG) pred_adc_config = v;
        else if (a == pmrs_pkg::ADDR_SHUNT_CAL) pred_shunt_cal = v;
      end
      pmrs_pkg::KIND_READ: begin
        r.count = pmrs_pkg::COUNT_SHORT;
        case (pred_pointer)
          pmrs_pkg::ADDR_CONFIG:     r.data = {pred_config, 8'h00};
          pmrs_pkg::ADDR_ADC_CONFIG: r.data = {pred_adc_config, 8'h00};
          pmrs_pkg::ADDR_SHUNT_CAL:  r.data = {pred_shunt_cal, 8'h00};
          pmrs_pkg::ADDR_MANUF_ID:   r.data = {pmrs_pkg::MANUF_ID_VALUE, 8'h00};
          pmrs_pkg::ADDR_DEVICE_ID:  r.data = {pmrs_pkg::DEVICE_ID_VALUE, 8'h00};
          pmrs_pkg::ADDR_VBUS: begin
            r.data  = {1'b0, pred_vbus_code, 4'h0};
            r.count = pmrs_pkg::COUNT_LONG;
          end
          pmrs_pkg::ADDR_CURRENT: begin
            r.data  = {pred_amps_code, 4'h0};
            r.count = pmrs_pkg::COUNT_LONG;
          end
          default: r.data = '0;
        endcase
      end
      default: begin
        pred_vbus_code = vbus_code_of(vbus);
        pred_amps_code = amps_code_of(amps);
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int sel;
    if (steady_flow) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 65) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_addr();
    case ($urandom_range(0, 10))
      0: return pmrs_pkg::ADDR_CONFIG;
      1: return pmrs_pkg::ADDR_ADC_CONFIG;
      2: return pmrs_pkg::ADDR_SHUNT_CAL;
      3: return pmrs_pkg::ADDR_VBUS;
      4: return pmrs_pkg::ADDR_CURRENT;
      5: return pmrs_pkg::ADDR_MANUF_ID;
      6: return pmrs_pkg::ADDR_DEVICE_ID;
      7: return 8'h04;
      8: return 8'h06;
      9: return 8'h08;
      default: return 8'($urandom);
    endcase
  endfunction

  // Q15.16 measurement level, biased toward rounding ties and clamp edges
  function automatic logic [31:0] pick_level();
    logic [31:0] lv;
    case ($urandom_range(0, 7))
      0, 1: lv = $urandom;
      2: lv = 32'($urandom_range(0, 4000)) - 32'd2000;
      3: lv = 32'd6710873 + 32'($urandom_range(0, 40)) - 32'd20;
      4: lv = 32'd13107175 + 32'($urandom_range(0, 50)) - 32'd25;
      5: lv = 32'd0 - 32'd13107200 + 32'($urandom_range(0, 50)) - 32'd25;
      6: begin
        if ($urandom_range(0, 1) == 0)
          lv = 32'd25 * 32'($urandom_range(0, 20000)) + 32'd12 + 32'($urandom_range(0, 1));
        else
          lv = 32'd64 * 32'($urandom_range(0, 100000)) + 32'd32;
        if ($urandom_range(0, 1) == 1) lv = -lv;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: lv = 32'h00000000;
          1: lv = 32'h00000001;
          2: lv = 32'hFFFFFFFF;
          3: lv = 32'h7FFFFFFF;
          default: lv = 32'h80000000;
        endcase
      end
    endcase
    return lv;
  endfunction

  // Drive one word at the falling edge, hold until accepted, log its reply
  task automatic send_word(input pmrs_pkg::kind_t k, input logic [7:0] a,
                           input logic [15:0] v,
                           input logic [31:0] vbus, input logic [31:0] amps,
                           input bit typed, input reply_t typed_reply);
    int gap;
    reply_t r;
    gap = pick_gap();
    for (int i = 0; i < gap; i++) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    kind         <= k;
    reg_address  <= a;
    write_value  <= v;
    bus_voltage  <= vbus;
    current_amps <= amps;
    do @(posedge clk); while (!in_ready);
    predict_reply(k, a, v, vbus, amps, r);
    pending_replies.push_back(typed ? typed_reply : r);
  endtask

  // Random word with every field at random
  task automatic send_noise();
    reply_t none;
    none = '{default: '0};
    send_word(pmrs_pkg::kind_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
              $urandom, $urandom, 1'b0, none);
  endtask

  // Reply checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("word with no reply waiting: data %h count %0d",
                                  read_data, byte_count));
      end else begin
        want_reply = pending_replies.pop_front();
        if (read_data !== want_reply.data)
          report_mismatch($sformatf("read_data %h, predicted %h", read_data, want_reply.data));
        if (byte_count !== want_reply.count)
          report_mismatch($sformatf("byte_count %0d, predicted %0d",
                                    byte_count, want_reply.count));
      end
    end
  end

  // Receiver: ready bursts broken by random stalls
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
  end

  // Watchdog on cycles with no accepted word on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_power_monitor_register_slave_core: FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    reply_t none;
    reply_t row_reply;
    int sent;
    logic [7:0] a;
    none         = '{default: '0};
    steady_flow  = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = pmrs_pkg::KIND_SET_PTR;
    reg_address  = '0;
    write_value  = '0;
    bus_voltage  = '0;
    current_amps = '0;
    pred_pointer    = '0;
    pred_config     = '0;
    pred_adc_config = '0;
    pred_shunt_cal  = '0;
    pred_vbus_code  = '0;
    pred_amps_code  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row_reply.data  = directed_rows[i].data;
      row_reply.count = directed_rows[i].count;
      send_word(directed_rows[i].k, directed_rows[i].addr, directed_rows[i].val,
                directed_rows[i].vbus, directed_rows[i].amps,
                directed_rows[i].typed, row_reply);
    end

    // Random sequences
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 19) == 0) steady_flow = !steady_flow;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // write then read back
          a = pick_addr();
          send_word(pmrs_pkg::KIND_WRITE, a, 16'($urandom), $urandom, $urandom,
                    1'b0, none);
          send_word(pmrs_pkg::KIND_READ, 8'($urandom), 16'($urandom), $urandom, $urandom,
                    1'b0, none);
          sent += 2;
        end
        3, 4: begin
          // measurement, then read both codes
          send_word(pmrs_pkg::KIND_MEAS, 8'($urandom), 16'($urandom),
                    pick_level(), pick_level(), 1'b0, none);
          send_word(($urandom_range(0, 3) == 0) ? pmrs_pkg::KIND_WRITE
                                                : pmrs_pkg::KIND_SET_PTR,
                    pmrs_pkg::ADDR_VBUS, 16'($urandom), $urandom, $urandom, 1'b0, none);
          send_word(pmrs_pkg::KIND_READ, 8'($urandom), 16'($urandom), $urandom, $urandom,
                    1'b0, none);
          send_word(pmrs_pkg::KIND_SET_PTR, pmrs_pkg::ADDR_CURRENT, 16'($urandom),
                    $urandom, $urandom, 1'b0, none);
          send_word(pmrs_pkg::KIND_READ, 8'($urandom), 16'($urandom), $urandom, $urandom,
                    1'b0, none);
          sent += 5;
        end
        5, 6: begin
          // pointer set then one or more reads
          send_word(pmrs_pkg::KIND_SET_PTR, pick_addr(), 16'($urandom), $urandom, $urandom,
                    1'b0, none);
          sent++;
          repeat ($urandom_range(1, 3)) begin
            send_word(pmrs_pkg::KIND_READ, 8'($urandom), 16'($urandom), $urandom,
                      $urandom, 1'b0, none);
            sent++;
          end
        end
        default: begin
          send_noise();
          sent++;
        end
      endcase
    end

    // Drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_power_monitor_register_slave_core: PASS");
    end else begin
      $display("tb_power_monitor_register_slave_core: FAIL");
    end
    $finish;
  end

endmodule
